@@ rtl/core/assert_macros.svh @@
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: property violated");
// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ rtl/core/rrts_pkg.sv @@
// package of types and constants for the round-robin task scheduler
package rrts_pkg;

    localparam int NUM_TASKS  = 64;
    localparam int TASK_ID_W  = $clog2(NUM_TASKS);
    localparam int RUN_W      = $clog2(NUM_TASKS + 1);
    localparam int CNT_W      = $clog2(NUM_TASKS + 1);

    localparam logic [RUN_W-1:0] IDLE_ID = RUN_W'(NUM_TASKS);

    // request codes
    localparam logic [1:0] REQ_SWITCH = 2'd0;
    localparam logic [1:0] REQ_BLOCK  = 2'd1;
    localparam logic [1:0] REQ_RESUME = 2'd2;

    localparam logic TSK_READY   = 1'b1;
    localparam logic TSK_WAITING = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

    // ring pointer step with wrap at the table depth
    function automatic logic [TASK_ID_W-1:0] ptr_next(input logic [TASK_ID_W-1:0] p);
        logic [TASK_ID_W-1:0] q;
        q = (p == TASK_ID_W'(NUM_TASKS - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

endpackage

@@ rtl/core/round_robin_task_scheduler.sv @@
// round-robin run-queue scheduler: top level
// order: a request is captured when accepted, then read in the read state and decided in the
//   execute state, where the result beat is registered; a new request may be accepted during
//   execute; busy is high only during the read cycle
// reset (synchronous, active low): all tasks blocked, queue empty, idle task running
// the result beat is a one-cycle strobe; the receiver cannot stall it
`include "assert_macros.svh"

module round_robin_task_scheduler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_req_type,
    input  logic [rrts_pkg::TASK_ID_W-1:0] i_task_id,
    input  logic                           i_current_destroyed,
    output logic                           o_valid,
    output logic [rrts_pkg::RUN_W-1:0]     o_running_task,
    output logic                           o_switched,
    output logic                           o_reload_quantum,
    output logic                           o_request_error
);
    import rrts_pkg::*;

    // ---------------------------------------------------------------
    // state: control flops, the run fifo memory and the runnable memory
    // ---------------------------------------------------------------
    t_state r_state, n_state;

    logic [TASK_ID_W-1:0] r_head, n_head;
    logic [TASK_ID_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [RUN_W-1:0]     r_current, n_current;

    // request captured on the accepted beat
    logic [1:0]           r_req;
    logic [TASK_ID_W-1:0] r_task_id;
    logic                 r_destroyed;

    // run fifo storage; the head entry is read on every read cycle but used only after it is written
    logic [TASK_ID_W-1:0] fifo_mem [NUM_TASKS];
    logic [TASK_ID_W-1:0] r_fifo_q;

    // runnable bits: memory plus per-entry valid flops, invalid reads as blocked
    logic                 rb_mem [NUM_TASKS];
    logic [NUM_TASKS-1:0] r_rb_valid;
    logic                 r_rb_q;
    logic                 r_rb_vq;

    // control decoded from the state
    logic accept;
    logic rd_en;
    logic ex_en;

    // write-back controls from the execute stage
    logic                 fifo_we;
    logic [TASK_ID_W-1:0] fifo_wdata;
    logic                 rb_we;
    logic [TASK_ID_W-1:0] rb_waddr;
    logic                 rb_wdata;
    logic [TASK_ID_W-1:0] rb_raddr;

    logic n_switched, n_reload, n_err;

    // ---------------------------------------------------------------
    // sequencer: idle -> read (busy) -> execute; a new beat may enter
    // during execute since its read cycle comes after the write-back
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = start ? ST_READ : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy   = (r_state == ST_READ);
        rd_en  = (r_state == ST_READ);
        ex_en  = (r_state == ST_EXEC);
        accept = start && (r_state != ST_READ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture the request beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req       <= i_req_type;
            r_task_id   <= i_task_id;
            r_destroyed <= i_current_destroyed;
        end
    end

    // ---------------------------------------------------------------
    // read cycle: fifo head entry and the runnable bit of the task in question
    // (the current task on a switch, the named task otherwise)
    // ---------------------------------------------------------------
    assign rb_raddr = (r_req == REQ_SWITCH) ? r_current[TASK_ID_W-1:0] : r_task_id;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_fifo_q <= fifo_mem[r_head];
            r_rb_q   <= rb_mem[rb_raddr];
        end
        if (fifo_we) begin
            fifo_mem[r_tail] <= fifo_wdata;
        end
        if (rb_we) begin
            rb_mem[rb_waddr] <= rb_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rb_valid <= '0;
            r_rb_vq    <= 1'b0;
        end else begin
            if (rd_en) r_rb_vq <= r_rb_valid[rb_raddr];
            if (rb_we) r_rb_valid[rb_waddr] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // execute cycle: decide, update pointers, write back
    // ---------------------------------------------------------------
    always_comb begin
        logic                 cur_is_task;
        logic                 sel_run;
        logic                 prev_run;
        logic [RUN_W-1:0]     next_task;
        logic [CNT_W-1:0]     cnt_pop;

        cur_is_task = (r_current < IDLE_ID);
        sel_run     = r_rb_q && r_rb_vq;
        prev_run    = cur_is_task && sel_run;
        next_task   = IDLE_ID;
        cnt_pop     = r_count;

        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_current  = r_current;
        n_switched = 1'b0;
        n_reload   = 1'b0;
        n_err      = 1'b0;
        fifo_we    = 1'b0;
        fifo_wdata = r_current[TASK_ID_W-1:0];
        rb_we      = 1'b0;
        rb_waddr   = r_task_id;
        rb_wdata   = TSK_WAITING;

        if (ex_en) begin
            unique case (r_req)
                REQ_SWITCH: begin
                    if (r_count != '0) begin
                        // pop the queue head
                        next_task = RUN_W'(r_fifo_q);
                        n_head    = ptr_next(r_head);
                        cnt_pop   = r_count - 1'b1;
                    end else if (prev_run && !r_destroyed) begin
                        next_task = r_current;
                    end else begin
                        next_task = IDLE_ID;
                    end
                    n_count  = cnt_pop;
                    n_reload = (next_task != IDLE_ID);
                    if (next_task != r_current) begin
                        // requeue a runnable outgoing task
                        if (prev_run && (cnt_pop < CNT_W'(NUM_TASKS))) begin
                            fifo_we    = 1'b1;
                            fifo_wdata = r_current[TASK_ID_W-1:0];
                            n_tail     = ptr_next(r_tail);
                            n_count    = cnt_pop + 1'b1;
                        end
                        n_current  = next_task;
                        n_switched = 1'b1;
                    end
                end
                REQ_BLOCK: begin
                    if (sel_run) begin
                        rb_we    = 1'b1;
                        rb_wdata = TSK_WAITING;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                REQ_RESUME: begin
                    if (!sel_run) begin
                        rb_we    = 1'b1;
                        rb_wdata = TSK_READY;
                        if (r_count < CNT_W'(NUM_TASKS)) begin
                            fifo_we    = 1'b1;
                            fifo_wdata = r_task_id;
                            n_tail     = ptr_next(r_tail);
                            n_count    = r_count + 1'b1;
                        end
                    end else begin
                        n_err = 1'b1;
                    end
                end
                default: begin
                    // unused request code is rejected
                    n_err = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_current <= IDLE_ID;
            o_valid   <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_current <= n_current;
            o_valid   <= ex_en;
        end
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        if (ex_en) begin
            o_running_task   <= n_current;
            o_switched       <= n_switched;
            o_reload_quantum <= n_reload;
            o_request_error  <= n_err;
        end
    end

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CNT_W'(NUM_TASKS))
    `ASSERT_NEVER(a_current_range, i_clk, i_rst_n, r_current > IDLE_ID)
    `ASSERT_ALWAYS(a_beat_after_exec, i_clk, i_rst_n, o_valid |-> $past(r_state == ST_EXEC))
    `ASSERT_ALWAYS(a_read_then_exec, i_clk, i_rst_n, busy |=> (ex_en && !busy))
    `ASSERT_NEVER(a_fifo_write_order, i_clk, i_rst_n, fifo_we && !ex_en)

endmodule

@@ bench/rrts_sched_scoreboard.sv @@
// scoreboard for the round-robin task scheduler: shadow run queue, predicted beats, field compare
`timescale 1ns / 1ps

module rrts_sched_scoreboard (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [1:0]                     i_req_type,
    input  logic [rrts_pkg::TASK_ID_W-1:0] i_task_id,
    input  logic                           i_current_destroyed,
    input  logic                           o_valid,
    input  logic [rrts_pkg::RUN_W-1:0]     o_running_task,
    input  logic                           o_switched,
    input  logic                           o_reload_quantum,
    input  logic                           o_request_error,
    output int                             n_fail,
    output int                             n_owed
);

    import rrts_pkg::*;

    // cap on printed mismatch lines
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [RUN_W-1:0] running;
        logic             switched;
        logic             reload;
        logic             err;
    } t_sched_beat;

    // shadow scheduler state
    logic                 task_ready [NUM_TASKS];
    logic [TASK_ID_W-1:0] run_ring [NUM_TASKS];
    logic [TASK_ID_W-1:0] ring_rd;
    logic [TASK_ID_W-1:0] ring_wr;
    logic [CNT_W-1:0]     ring_fill;
    logic [RUN_W-1:0]     cur_task;

    t_sched_beat          owed_beats[$];
    t_sched_beat          want_beat;

    function automatic logic is_ready(input logic [RUN_W-1:0] id);
        return (id < NUM_TASKS) && (task_ready[id[TASK_ID_W-1:0]] == TSK_READY);
    endfunction

    // append to the run ring, dropped when the ring is full
    task automatic ring_append(input logic [TASK_ID_W-1:0] id);
        if (ring_fill < CNT_W'(NUM_TASKS)) begin
            run_ring[ring_wr] = id;
            ring_wr = TASK_ID_W'((int'(ring_wr) + 1) % NUM_TASKS);
            ring_fill = ring_fill + 1'b1;
        end
    endtask

    task automatic schedule_request(input  logic [1:0]           req,
                                    input  logic [TASK_ID_W-1:0] id,
                                    input  logic                 destroyed,
                                    output t_sched_beat          beat);
        logic [RUN_W-1:0] prev_task;
        logic [RUN_W-1:0] pick;
        beat = '0;
        case (req)
            REQ_SWITCH: begin
                prev_task = cur_task;
                // queue head wins, even a task blocked since it was queued
                if (ring_fill != 0) begin
                    pick = RUN_W'(run_ring[ring_rd]);
                    ring_rd = TASK_ID_W'((int'(ring_rd) + 1) % NUM_TASKS);
                    ring_fill = ring_fill - 1'b1;
                end else if (is_ready(prev_task) && !destroyed) begin
                    pick = prev_task;
                end else begin
                    pick = IDLE_ID;
                end
                beat.reload = (pick != IDLE_ID);
                if (pick != prev_task) begin
                    if (is_ready(prev_task))
                        ring_append(prev_task[TASK_ID_W-1:0]);
                    cur_task = pick;
                    beat.switched = 1'b1;
                end
            end
            REQ_BLOCK: begin
                if (task_ready[id] == TSK_READY)
                    task_ready[id] = TSK_WAITING;
                else
                    beat.err = 1'b1;
            end
            REQ_RESUME: begin
                if (task_ready[id] == TSK_WAITING) begin
                    task_ready[id] = TSK_READY;
                    ring_append(id);
                end else begin
                    beat.err = 1'b1;
                end
            end
            default: beat.err = 1'b1;
        endcase
        beat.running = cur_task;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_TASKS; t++)
                task_ready[t] = TSK_WAITING;
            ring_rd   = '0;
            ring_wr   = '0;
            ring_fill = '0;
            cur_task  = IDLE_ID;
            owed_beats.delete();
        end else begin
            if (o_valid !== 1'b0) begin
                if (owed_beats.size() == 0) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $display("%0t: result beat with nothing expected, expected none actual %0d",
                                 $time, o_running_task);
                end else begin
                    want_beat = owed_beats.pop_front();
                    check_field("running_task", 8'(want_beat.running), 8'(o_running_task));
                    check_field("switched", 8'(want_beat.switched), 8'(o_switched));
                    check_field("reload_quantum", 8'(want_beat.reload), 8'(o_reload_quantum));
                    check_field("request_error", 8'(want_beat.err), 8'(o_request_error));
                end
            end
            if (start && !busy) begin
                schedule_request(i_req_type, i_task_id, i_current_destroyed, want_beat);
                owed_beats.push_back(want_beat);
            end
        end
        n_owed = owed_beats.size();
    end

endmodule

@@ bench/tb_round_robin_task_scheduler.sv @@
// testbench top for the round-robin task scheduler: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb_round_robin_task_scheduler;

    import rrts_pkg::*;

    // request code the block must reject
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // random item count and cycles without any beat before giving up
    localparam int RANDOM_ITEMS = 1700;
    localparam int STALL_LIMIT  = 2000;

    // traffic shapes for the random part
    typedef enum {
        MODE_MIX,
        MODE_FILL,
        MODE_DRAIN
    } t_traffic;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           i_req_type = REQ_SWITCH;
    logic [TASK_ID_W-1:0] i_task_id = '0;
    logic                 i_current_destroyed = 1'b0;
    logic                 o_valid;
    logic [RUN_W-1:0]     o_running_task;
    logic                 o_switched;
    logic                 o_reload_quantum;
    logic                 o_request_error;

    int n_fail;
    int n_owed;
    int burst_left = 0;
    int stall_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    round_robin_task_scheduler DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_req_type          (i_req_type),
        .i_task_id           (i_task_id),
        .i_current_destroyed (i_current_destroyed),
        .o_valid             (o_valid),
        .o_running_task      (o_running_task),
        .o_switched          (o_switched),
        .o_reload_quantum    (o_reload_quantum),
        .o_request_error     (o_request_error)
    );

    rrts_sched_scoreboard u_sched_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_req_type          (i_req_type),
        .i_task_id           (i_task_id),
        .i_current_destroyed (i_current_destroyed),
        .o_valid             (o_valid),
        .o_running_task      (o_running_task),
        .o_switched          (o_switched),
        .o_reload_quantum    (o_reload_quantum),
        .o_request_error     (o_request_error),
        .n_fail              (n_fail),
        .n_owed              (n_owed)
    );

    // one request beat; start stays high through a burst, gaps of random
    // length between bursts so idle cycles land on both phases of the block
    task automatic send(input logic [1:0] req, input logic [TASK_ID_W-1:0] id,
                        input logic destroyed);
        int gap;
        start               <= 1'b1;
        i_req_type          <= req;
        i_task_id           <= id;
        i_current_destroyed <= destroyed;
        do @(posedge i_clk); while (busy);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            // now and then a long burst with no gaps at all
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(0, 12);
        end
    endtask

    // watchdog: cycles in which no request and no result is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("** round_robin_task_scheduler: FAILED **");
            $finish;
        end
    end

    initial begin
        t_traffic mode;
        int       phase_left;
        int       sent;
        int       roll;
        int       hot_id;
        logic [1:0]           req;
        logic [TASK_ID_W-1:0] id;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // switch right after reset: idle stays idle, no reload
        send(REQ_SWITCH, 6'd0, 1'b0);
        // block of a task that is already blocked
        send(REQ_BLOCK, 6'd0, 1'b0);
        // resume, then resume again while runnable
        send(REQ_RESUME, 6'd0, 1'b0);
        send(REQ_RESUME, 6'd0, 1'b0);
        send(REQ_RESUME, 6'd63, 1'b0);
        // unused request code
        send(REQ_UNUSED, 6'd42, 1'b0);
        // idle to task 0, then the head wins although current is destroyed
        send(REQ_SWITCH, 6'd0, 1'b0);
        send(REQ_SWITCH, 6'd0, 1'b1);
        // block the running task; the switch must not requeue it
        send(REQ_BLOCK, 6'd63, 1'b0);
        send(REQ_SWITCH, 6'd0, 1'b0);
        // empty queue, current runnable: it continues with a fresh quantum
        send(REQ_SWITCH, 6'd0, 1'b0);
        // destroyed current falls to idle but is still queued
        send(REQ_SWITCH, 6'd0, 1'b1);
        send(REQ_SWITCH, 6'd0, 1'b0);
        // a task blocked after queueing still runs from the head
        send(REQ_RESUME, 6'd21, 1'b0);
        send(REQ_BLOCK, 6'd21, 1'b0);
        send(REQ_SWITCH, 6'd0, 1'b0);
        send(REQ_SWITCH, 6'd0, 1'b1);
        // nothing runnable at all: idle
        send(REQ_BLOCK, 6'd0, 1'b0);
        send(REQ_SWITCH, 6'd0, 1'b0);
        send(REQ_BLOCK, 6'd42, 1'b0);
        send(REQ_RESUME, 6'd42, 1'b0);
        send(REQ_UNUSED, 6'd63, 1'b1);
        send(REQ_SWITCH, 6'd0, 1'b1);

        // random part: the first phase fills the run queue past its depth
        // through resume/block churn, later phases mix, drain and refill
        sent       = 0;
        mode       = MODE_FILL;
        phase_left = 400;
        hot_id     = $urandom_range(60);
        while (sent < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                case ($urandom_range(2))
                    0:       mode = MODE_MIX;
                    1:       mode = MODE_FILL;
                    default: mode = MODE_DRAIN;
                endcase
                phase_left = $urandom_range(60, 250);
                hot_id     = $urandom_range(60);
            end
            roll = $urandom_range(99);
            case (mode)
                MODE_FILL:
                    req = (roll < 3)  ? REQ_SWITCH : (roll < 40) ? REQ_BLOCK :
                          (roll < 97) ? REQ_RESUME : REQ_UNUSED;
                MODE_DRAIN:
                    req = (roll < 75) ? REQ_SWITCH : (roll < 85) ? REQ_BLOCK :
                          (roll < 97) ? REQ_RESUME : REQ_UNUSED;
                default:
                    req = (roll < 40) ? REQ_SWITCH : (roll < 65) ? REQ_BLOCK :
                          (roll < 95) ? REQ_RESUME : REQ_UNUSED;
            endcase
            // a small hot set of tasks gets reused so runnable and queued states collide
            if ($urandom_range(3) == 0)
                id = TASK_ID_W'(hot_id + $urandom_range(3));
            else
                id = TASK_ID_W'($urandom_range(NUM_TASKS - 1));
            send(req, id, ($urandom_range(3) == 0));
            sent++;
            phase_left--;
        end
        start <= 1'b0;

        // drain outstanding results, then wait for any stray beat
        while (n_owed != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (n_fail == 0)
            $display("** round_robin_task_scheduler: PASSED **");
        else
            $display("** round_robin_task_scheduler: FAILED **");
        $finish;
    end

endmodule
